[rtl/csvs_pkg.sv]
// Package for the CSV line field splitter: item types, command word type and byte constants.
// No dependencies; every other file imports it.
package csvs_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Depth of the command queue between front and back.
  localparam int unsigned CMDQ_DEPTH = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       field_end;
    logic       line_end;
    logic       ws_overflow;
  } out_item_t;

  // One command word: the back carries the flagged steps out in this order.
  typedef struct packed {
    logic       wr_ws;     // append one held whitespace entry
    logic       ws_tab;    // that entry is a tab
    logic       flush;     // emit every held whitespace entry
    logic       emit_data; // emit a content byte
    logic [7:0] data;
    logic       emit_fe;   // emit a field end (separator)
    logic       fe_ov;
    logic       emit_le;   // emit the final field end of the line
    logic       le_ov;
  } cmd_t;

endpackage

[rtl/csvs_front.sv]
// Front part of the CSV line field splitter: takes input bytes, classifies them and issues
// command words. Depends on csvs_pkg.
module csvs_front
  import csvs_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_data,
  input  logic [7:0] sep,
  output logic       q_push,
  output cmd_t       q_data,
  input  logic       q_full
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic             in_quotes_r, in_quotes_nxt;
  logic             at_start_r, at_start_nxt;
  logic             closed_r, closed_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             is_ws;
  logic [7:0]       b;
  cmd_t             cmd;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign b      = in_data.in_byte;
  assign is_ws  = (b != sep) && ((b == CH_SPACE) || (b == CH_TAB));

  always_comb begin
    in_quotes_nxt = in_quotes_r;
    at_start_nxt  = at_start_r;
    closed_nxt    = closed_r;
    ovf_nxt       = ovf_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    if (is_ws) begin
      if (!at_start_r && !closed_r) begin
        if (cnt_r < CNT_W'(DEPTH)) begin
          cmd.wr_ws  = 1'b1;
          cmd.ws_tab = (b == CH_TAB);
          cnt_nxt    = cnt_r + CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end else if (b == CH_QUOTE) begin
      in_quotes_nxt = !in_quotes_r;
      if (!at_start_r && !closed_r) begin
        cmd.flush  = (cnt_r != '0);
        cnt_nxt    = '0;
        closed_nxt = 1'b1;
      end
    end else if (!in_quotes_r && (b == sep)) begin
      cmd.emit_fe  = 1'b1;
      cmd.fe_ov    = ovf_r;
      at_start_nxt = 1'b1;
      closed_nxt   = 1'b0;
      cnt_nxt      = '0;
      ovf_nxt      = 1'b0;
    end else if (!closed_r) begin
      cmd.flush    = (cnt_r != '0);
      cnt_nxt      = '0;
      at_start_nxt = 1'b0;
      if (b == CH_NUL) begin
        closed_nxt = 1'b1;
      end else begin
        cmd.emit_data = 1'b1;
        cmd.data      = b;
      end
    end

    // End of line: final field end, then everything back to its reset value
    if (in_data.line_last) begin
      cmd.emit_le   = 1'b1;
      cmd.le_ov     = ovf_nxt;
      in_quotes_nxt = 1'b0;
      at_start_nxt  = 1'b1;
      closed_nxt    = 1'b0;
      cnt_nxt       = '0;
      ovf_nxt       = 1'b0;
    end
  end

  assign q_data = cmd;
  assign q_push = accept && (cmd.wr_ws || cmd.flush || cmd.emit_data ||
                             cmd.emit_fe || cmd.emit_le);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r <= 1'b0;
      at_start_r  <= 1'b1;
      closed_r    <= 1'b0;
      ovf_r       <= 1'b0;
      cnt_r       <= '0;
    end else if (accept) begin
      in_quotes_r <= in_quotes_nxt;
      at_start_r  <= at_start_nxt;
      closed_r    <= closed_nxt;
      ovf_r       <= ovf_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

[rtl/csvs_cmdq.sv]
// Short command queue between front and back of the CSV line field splitter.
// Depends on csvs_pkg for the command word type and queue depth.
module csvs_cmdq
  import csvs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  localparam int unsigned PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/csvs_back.sv]
// Back part of the CSV line field splitter: carries out command words, holds the whitespace
// store and drives the result register. Depends on csvs_pkg.
module csvs_back
  import csvs_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      q_data,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             cmd_r, cmd_nxt;
  logic             cmd_valid_r, cmd_valid_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEPTH-1:0] tab_r, tab_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  out_item_t        res;
  logic             emit;
  logic             out_free;
  logic             done;

  assign out_free = !out_valid_r || pop;

  always_comb begin
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    tab_nxt       = tab_r;
    emit          = 1'b0;
    res           = '0;
    cmd_valid_nxt = cmd_valid_r;
    q_pop         = 1'b0;

    if (cmd_valid_r) begin
      priority if (cmd_r.wr_ws) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (cnt_r == CNT_W'(i)) begin
            tab_nxt[i] = cmd_r.ws_tab;
          end
        end
        cnt_nxt       = cnt_r + CNT_W'(1);
        cmd_nxt.wr_ws = 1'b0;
      end else if (cmd_r.flush && (cnt_r != '0)) begin
        if (out_free) begin
          emit         = 1'b1;
          res.out_byte = tab_r[0] ? CH_TAB : CH_SPACE;
          tab_nxt      = tab_r >> 1;
          cnt_nxt      = cnt_r - CNT_W'(1);
        end
      end else if (cmd_r.emit_data) begin
        if (out_free) begin
          emit              = 1'b1;
          res.out_byte      = cmd_r.data;
          cmd_nxt.flush     = 1'b0;
          cmd_nxt.emit_data = 1'b0;
        end
      end else if (cmd_r.emit_fe) begin
        if (out_free) begin
          emit            = 1'b1;
          res.field_end   = 1'b1;
          res.ws_overflow = cmd_r.fe_ov;
          cnt_nxt         = '0;
          cmd_nxt.flush   = 1'b0;
          cmd_nxt.emit_fe = 1'b0;
        end
      end else if (cmd_r.emit_le) begin
        if (out_free) begin
          emit            = 1'b1;
          res.field_end   = 1'b1;
          res.line_end    = 1'b1;
          res.ws_overflow = cmd_r.le_ov;
          cnt_nxt         = '0;
          cmd_nxt.flush   = 1'b0;
          cmd_nxt.emit_le = 1'b0;
        end
      end else begin
        cmd_nxt.flush = 1'b0;
      end
    end

    done = !(cmd_nxt.wr_ws || (cmd_nxt.flush && (cnt_nxt != '0)) || cmd_nxt.emit_data ||
             cmd_nxt.emit_fe || cmd_nxt.emit_le);

    // Load the next word as soon as the current one finishes
    if (!cmd_valid_r || done) begin
      cmd_valid_nxt = 1'b0;
      if (!q_empty) begin
        q_pop         = 1'b1;
        cmd_nxt       = q_data;
        cmd_valid_nxt = 1'b1;
      end
    end

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    tab_r <= tab_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("held whitespace count beyond store depth");

  a_fe_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.field_end |-> out_r.out_byte == 8'h00)
    else $error("field end carries a byte");

  a_le_is_fe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.line_end |-> out_r.field_end)
    else $error("line end without field end");

  a_ov_on_fe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.ws_overflow |-> out_r.field_end)
    else $error("overflow flag on a content word");
`endif

endmodule

[rtl/csv_line_field_splitter.sv]
// Top level of the CSV line field splitter: configuration register, front, command queue, back.
// Depends on csvs_pkg, csvs_front, csvs_cmdq and csvs_back.
//
// Usage:
//   Input channel: a queue sink. Present one byte of the line with line_last on in_data,
//   raise push; the word is taken at a rising edge where push is high and full is low.
//   Result channel: a queue source. While empty is low the oldest result is on out_data;
//   raise pop to take it. Content words carry out_byte; field ends carry field_end, and the
//   final field end of a line also carries line_end. ws_overflow on a field end says held
//   whitespace beyond HELD_WS_DEPTH entries was dropped in that field.
//   Configuration: APB write of the separator byte at address 0, only while the block is idle.
// Path: the first result of a byte passes through the queue, written at the edge that takes
//   the byte, then the back command register, then the result register.
// Throughput: one byte per cycle while each byte gives at most one result and pop stays high.
//   A byte that releases held whitespace holds the back for each entry, then for any content
//   byte and line end; a whitespace byte that ends the line, for its store write and line end.
//   The two-word command queue absorbs short bursts, then full rises until the back drains.
// Reset (synchronous, rst_n low): separator 0, parsing state at field start outside quotes,
//   queue and result register empty. The whitespace store needs no clearing.
// When the receiver stalls, the result register holds its word, the back and then the
//   queue fill, and full rises; nothing is lost.
module csv_line_field_splitter
  import csvs_pkg::*;
#(
  parameter int unsigned HELD_WS_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  in_item_t    in_data,
  // result channel
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] sep_r;
  logic       cfg_wr;
  logic       sel_sep;

  logic       q_push;
  cmd_t       q_wdata;
  logic       q_full;
  logic       q_pop;
  cmd_t       q_rdata;
  logic       q_empty;

  // Register decode: one word-aligned register at index 0
  assign pready  = 1'b1;
  assign sel_sep = (paddr[2] == 1'b0);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = sel_sep ? {24'h000000, sep_r} : 32'h00000000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= 8'h00;
    end else if (cfg_wr && sel_sep) begin
      sep_r <= pwdata[7:0];
    end
  end

  // Front: classify each byte, track quote and field state, issue command words
  csvs_front #(
    .DEPTH (HELD_WS_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .sep     (sep_r),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  // Queue: decouple the front from back-pressure on the result side
  csvs_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // Back: hold whitespace, release it before content, emit field and line ends
  csvs_back #(
    .DEPTH (HELD_WS_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

[test/csvs_checker.sv]
// Checker for the CSV line field splitter: follows the separator register, predicts
// the result words of every byte taken and compares them with the words popped.
// Depends on csvs_pkg for the word types and the byte constants.
`timescale 1ns / 1ps

module csvs_checker
  import csvs_pkg::*;
#(
  parameter int unsigned HELD_WS_DEPTH = 32,
  parameter logic [2:0]  SEP_ADDR      = 3'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  in_item_t    in_data,
  input  logic        empty,
  input  logic        pop,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned fail_count,
  output int unsigned pending
);

  logic [7:0]  sep_q;
  logic        quoted;
  logic        at_start;
  logic        closed;
  int unsigned held_cnt;
  logic        held_tab [HELD_WS_DEPTH];
  logic        ovf;
  int unsigned errs;
  out_item_t   field_words [$];

  initial begin
    errs       = 0;
    fail_count = 0;
    pending    = 0;
  end

  function automatic void add_word(logic [7:0] b, logic fe, logic le, logic ov);
    out_item_t w;
    w.out_byte    = b;
    w.field_end   = fe;
    w.line_end    = le;
    w.ws_overflow = ov;
    field_words.insert(field_words.size(), w);
  endfunction

  function automatic void emit_held_ws();
    for (int i = 0; i < held_cnt; i++)
      add_word(held_tab[i] ? CH_TAB : CH_SPACE, 1'b0, 1'b0, 1'b0);
    held_cnt = 0;
  endfunction

  function automatic void start_field();
    at_start = 1'b1;
    closed   = 1'b0;
    held_cnt = 0;
    ovf      = 1'b0;
  endfunction

  function automatic void split_byte(in_item_t it);
    logic [7:0] b;
    logic       ws;
    b  = it.in_byte;
    // a blank that is the separator splits instead
    ws = (b != sep_q) && (b == CH_SPACE || b == CH_TAB);
    if (ws) begin
      if (!at_start && !closed) begin
        if (held_cnt < HELD_WS_DEPTH) begin
          held_tab[held_cnt] = (b == CH_TAB);
          held_cnt++;
        end else begin
          ovf = 1'b1;
        end
      end
    end else if (b == CH_QUOTE) begin
      quoted = !quoted;
      if (!at_start && !closed) begin
        emit_held_ws();
        closed = 1'b1;
      end
    end else if (!quoted && b == sep_q) begin
      add_word(8'h00, 1'b1, 1'b0, ovf);
      start_field();
    end else if (!closed) begin
      emit_held_ws();
      at_start = 1'b0;
      if (b == CH_NUL) closed = 1'b1;
      else add_word(b, 1'b0, 1'b0, 1'b0);
    end
    if (it.line_last) begin
      add_word(8'h00, 1'b1, 1'b1, ovf);
      quoted = 1'b0;
      start_field();
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      sep_q  = 8'h00;
      quoted = 1'b0;
      start_field();
      field_words.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == SEP_ADDR)
        sep_q = pwdata[7:0];
      if (push && !full)
        split_byte(in_data);
      if (pop && !empty) begin
        if (field_words.size() == 0) begin
          $error("unexpected word: out_byte %0h field_end %0b line_end %0b ws_overflow %0b",
                 out_data.out_byte, out_data.field_end, out_data.line_end,
                 out_data.ws_overflow);
          errs++;
        end else begin
          want = field_words.pop_front();
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("field_end", want.field_end, out_data.field_end);
          check_field("line_end", want.line_end, out_data.line_end);
          check_field("ws_overflow", want.ws_overflow, out_data.ws_overflow);
        end
      end
    end
    pending    <= field_words.size();
    fail_count <= errs;
  end

endmodule

[test/tb_csv_line_field_splitter.sv]
// Testbench top for the CSV line field splitter: clock, reset, byte and result
// traffic, separator writes, watchdog and verdict.
// Depends on csvs_pkg, csv_line_field_splitter and csvs_checker.
`timescale 1ns / 1ps

module tb_csv_line_field_splitter;
  import csvs_pkg::*;

  localparam int unsigned WS_DEPTH     = 32;
  localparam logic [2:0]  SEP_ADDR     = 3'd0;
  // the back holds a command register and a result register; give held whitespace time to settle too
  localparam int unsigned SETTLE       = 10;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned PHASE_WORDS  = 44;

  // directed lines: the first runs with the reset separator (NUL), the second
  // with a comma, the third with a space as separator
  localparam logic [7:0] LINE_NUL [11] = '{8'h00, 8'h20, 8'h22, 8'h41, 8'h20, 8'h09,
                                           8'h42, 8'h22, 8'h43, 8'h00, 8'hFF};
  localparam logic [7:0] LINE_COMMA [7] = '{8'h00, 8'h41, 8'h2C, 8'h22, 8'h2C,
                                            8'h22, 8'h20};
  localparam logic [7:0] LINE_SPACE [6] = '{8'h20, 8'h09, 8'h61, 8'h09, 8'h20, 8'h22};
  // separators of the random phases; a last phase draws its own
  localparam logic [7:0] SEP_PLAN [7] = '{8'h2C, 8'hFF, 8'h00, 8'h09, 8'h22, 8'h20, 8'h3B};

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  in_item_t    in_data;
  logic        empty;
  logic        pop;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned words_sent;
  int unsigned idle_cycles;
  int unsigned rx_hold_cycles;
  logic        tx_busy;
  logic        rx_busy;
  logic [7:0]  cur_sep;
  logic [7:0]  line_q [$];

  csv_line_field_splitter #(
    .HELD_WS_DEPTH(WS_DEPTH)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  csvs_checker #(
    .HELD_WS_DEPTH(WS_DEPTH),
    .SEP_ADDR     (SEP_ADDR)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .fail_count(fail_count),
    .pending   (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: count cycles in which no word moves on either side and no
  // register access is under way; a correct run never idles this long.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side: wait a random number of cycles before each word, with
  // stretches of back-to-back pops. A requested hold-off is added to the
  // next gap, so the block backs up while the sender keeps offering bytes.
  initial begin : result_sink
    int unsigned gap;
    pop     <= 1'b0;
    rx_busy  = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_busy = !rx_busy;
      gap            = rx_busy ? $urandom_range(0, 15) : 0;
      gap           += rx_hold_cycles;
      rx_hold_cycles = 0;
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Offer one byte; push stays high into the next word when no gap is drawn.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_busy = !tx_busy;
    gap = tx_busy ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= '{in_byte: b, line_last: last};
    push    <= 1'b1;
    do @(posedge clk); while (full);
    words_sent++;
  endtask

  // Append one byte to the line under construction.
  function automatic void add_byte(input logic [7:0] b);
    line_q.insert(line_q.size(), b);
  endfunction

  task automatic send_line();
    if (line_q.size() == 0) add_byte(8'h61);
    foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  // Pause the sender until every predicted word has been popped, then let a
  // byte that left no word (held whitespace) settle in the back.
  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_separator(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEP_ADDR;
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_sep  = value;
  endtask

  function automatic logic [7:0] blank_byte();
    return ($urandom_range(0, 2) == 0) ? CH_TAB : CH_SPACE;
  endfunction

  // Anything at all, weighted towards the bytes the splitter treats specially.
  function automatic logic [7:0] noise_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return cur_sep;
    if (r < 20) return CH_QUOTE;
    if (r < 32) return CH_SPACE;
    if (r < 40) return CH_TAB;
    if (r < 44) return CH_NUL;
    if (r < 75) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(0, 255));
  endfunction

  // Build one line into line_q: mostly fields with padding, optional quoting,
  // inner blanks (now and then a run past the store depth) and a hidden tail;
  // the rest is plain noise.
  task automatic build_line();
    int unsigned fields;
    int unsigned n;
    logic        quoted_field;
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) add_byte(noise_byte());
    end else begin
      fields = $urandom_range(1, 5);
      for (int f = 0; f < fields; f++) begin
        repeat ($urandom_range(0, 2)) add_byte(blank_byte());
        quoted_field = ($urandom_range(0, 3) == 0);
        if (quoted_field) add_byte(CH_QUOTE);
        n = $urandom_range(0, 6);
        for (int j = 0; j < n; j++) begin
          case ($urandom_range(0, 9))
            0, 1: add_byte(blank_byte());
            2: add_byte(quoted_field ? cur_sep : noise_byte());
            3: begin
              if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(30, 40)) add_byte(blank_byte());
              else
                add_byte(noise_byte());
            end
            default: add_byte(8'($urandom_range(8'h61, 8'h7A)));
          endcase
        end
        if (quoted_field) add_byte(CH_QUOTE);
        if ($urandom_range(0, 5) == 0) begin
          add_byte($urandom_range(0, 1) ? CH_NUL : CH_QUOTE);
          repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(8'h61, 8'h7A)));
        end
        repeat ($urandom_range(0, 2)) add_byte(blank_byte());
        if (f != fields - 1) add_byte(cur_sep);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    logic [7:0]  sep;
    rst_n          <= 1'b0;
    push           <= 1'b0;
    in_data        <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    tx_busy         = 1'b0;
    rx_hold_cycles  = 0;
    words_sent      = 0;
    cur_sep         = 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: NUL as separator and as field start, stripped leading
    // padding and quotes, hidden tail after a closing quote, a quoted
    // separator, trailing blank on the last byte, blank as separator and an
    // unclosed quote at end of line.
    foreach (LINE_NUL[i]) add_byte(LINE_NUL[i]);
    send_line();
    wait_idle();
    write_separator(8'h2C);
    foreach (LINE_COMMA[i]) add_byte(LINE_COMMA[i]);
    send_line();
    wait_idle();
    write_separator(8'h20);
    foreach (LINE_SPACE[i]) add_byte(LINE_SPACE[i]);
    send_line();

    // Random phases, one separator each; the sender drains between them.
    for (int p = 0; p <= 7; p++) begin
      sep = (p < 7) ? SEP_PLAN[p] : 8'($urandom_range(0, 255));
      wait_idle();
      write_separator(sep);
      // hold the result side off once so the block fills and raises full
      if (p == 1) rx_hold_cycles = HOLD_CYCLES;
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        build_line();
        send_line();
      end
    end

    wait_idle();
    if (fail_count == 0 && pending_words == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
